>>> rtl/core/wfc_pkg.sv
`timescale 1ns / 1ps

package wfc_pkg;

    localparam int SSID_MAX_OCTETS      = 32;
    localparam int SNAP_SCAN_LAST_START = 40;

    localparam int SSID_LEN_W    = $clog2(SSID_MAX_OCTETS + 1);
    localparam int SSID_IDX_W    = (SSID_MAX_OCTETS > 1) ? $clog2(SSID_MAX_OCTETS) : 1;
    // one bank per frame in flight: front fills one, back drains the other
    localparam int SSID_RAM_AW    = SSID_IDX_W + 1;
    localparam int SSID_RAM_DEPTH = 2 ** SSID_RAM_AW;
    localparam int EAPOL_START_W  = $clog2(SNAP_SCAN_LAST_START + 8);

    localparam logic [7:0]  SSID_MAX_LEN   = 8'(SSID_MAX_OCTETS);
    localparam logic [15:0] IE_WALK_START  = 16'd36;
    localparam logic [15:0] POS_SATURATED  = 16'hFFFF;
    localparam logic [63:0] SNAP_PATTERN   = 64'hAAAA_0300_0000_888E;
    localparam logic [15:0] SNAP_FIRST_END = 16'd31;
    localparam logic [15:0] SNAP_LAST_END  = 16'(SNAP_SCAN_LAST_START + 6);
    localparam logic [15:0] BSSID_MIN_LEN  = 16'd22;
    localparam logic [15:0] EAPOL_MIN_LEN  = 16'd99;

    localparam logic [7:0] BEACON_MASK    = 8'hFC;
    localparam logic [7:0] BEACON_CODE    = 8'h80;
    localparam logic [7:0] EAPOL_KEY_TYPE = 8'h03;
    localparam logic [7:0] KEY_DESC_RSN   = 8'h02;
    localparam logic [7:0] KEY_DESC_WPA   = 8'hFE;

    localparam int KI_PAIRWISE = 3;
    localparam int KI_INSTALL  = 6;
    localparam int KI_ACK      = 7;
    localparam int KI_MIC      = 8;
    localparam int KI_SECURE   = 9;

    typedef enum logic [2:0] {
        MSG_UNKNOWN = 3'd0,
        MSG_M1      = 3'd1,
        MSG_M2      = 3'd2,
        MSG_M3      = 3'd3,
        MSG_M4      = 3'd4
    } msg_t;

    typedef struct packed {
        logic                     beacon;
        logic                     bssid_valid;
        logic [47:0]              bssid;
        logic                     ssid_found;
        logic [SSID_LEN_W-1:0]    ssid_len;
        logic                     eapol_found;
        logic [EAPOL_START_W-1:0] eapol_offset;
        logic [15:0]              eapol_length;
        msg_t                     msg;
        logic                     bank;
    } frame_job_t;

    typedef struct packed {
        logic                   en;
        logic [SSID_RAM_AW-1:0] addr;
        logic [7:0]             data;
    } ssid_wr_t;

endpackage

>>> rtl/core/wfc_in_if.sv
`timescale 1ns / 1ps

interface wfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/core/wfc_out_if.sv
`timescale 1ns / 1ps

interface wfc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        beacon_flag;
    logic        bssid_valid;
    logic [47:0] bssid_value;
    logic        ssid_found;
    logic [5:0]  ssid_length;
    logic        eapol_found;
    logic [5:0]  eapol_offset;
    logic [15:0] eapol_length;
    logic [2:0]  handshake_message;
    logic [7:0]  ssid_octet;
    logic        last_result;

    modport source (
        output valid, output result_kind, output beacon_flag, output bssid_valid,
        output bssid_value, output ssid_found, output ssid_length, output eapol_found,
        output eapol_offset, output eapol_length, output handshake_message,
        output ssid_octet, output last_result,
        input  ready
    );
    modport sink (
        input  valid, input result_kind, input beacon_flag, input bssid_valid,
        input  bssid_value, input ssid_found, input ssid_length, input eapol_found,
        input  eapol_offset, input eapol_length, input handshake_message,
        input  ssid_octet, input last_result,
        output ready
    );
endinterface

>>> rtl/core/wfc_ram.sv
`timescale 1ns / 1ps

module wfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/wfc_front.sv
`timescale 1ns / 1ps

module wfc_front (
    input  logic                clk,
    input  logic                rst_n,
    wfc_in_if.sink              octets,
    input  logic                q_full,
    output logic                push,
    output wfc_pkg::frame_job_t push_job,
    output wfc_pkg::ssid_wr_t   ssid_wr
);

    typedef enum logic [1:0] {
        WALK_SEARCH,
        WALK_CAPTURE,
        WALK_FAILED
    } walk_t;

    logic [15:0] pos_reg, pos_next;
    logic [55:0] tail_reg, tail_next;
    logic [7:0]  type_reg, type_next;
    logic [1:0]  ds_reg, ds_next;
    logic [47:0] bssid_reg, bssid_next;
    logic [15:0] enp_reg, enp_next;
    logic [7:0]  eid_reg, eid_next;
    logic [7:0]  ilen_reg, ilen_next;
    walk_t       walk_reg, walk_next;
    logic        ef_reg, ef_next;
    logic [wfc_pkg::EAPOL_START_W-1:0] es_reg, es_next;
    logic [7:0]  ktype_reg, ktype_next;
    logic [7:0]  kdesc_reg, kdesc_next;
    logic [15:0] ki_reg, ki_next;
    logic        finish_reg, finish_next;
    logic        bank_reg, bank_next;

    logic        take;
    logic [7:0]  b;
    logic [16:0] p17, enp17, walk_end17, ssid_first17, ssid_end17, ssid_off17;
    logic [15:0] bssid_base, es16, elen;
    logic        in_bssid, snap_hit, ssid_ok, len_ok;
    logic [63:0] tail_full;

    function automatic wfc_pkg::msg_t classify(
        input logic [15:0] len,
        input logic [7:0]  ty,
        input logic [7:0]  desc,
        input logic [15:0] ki
    );
        logic ack, mic, ins, sec;
        wfc_pkg::msg_t m;
        ack = ki[wfc_pkg::KI_ACK];
        mic = ki[wfc_pkg::KI_MIC];
        ins = ki[wfc_pkg::KI_INSTALL];
        sec = ki[wfc_pkg::KI_SECURE];
        m   = wfc_pkg::MSG_UNKNOWN;
        if (len >= wfc_pkg::EAPOL_MIN_LEN && ty == wfc_pkg::EAPOL_KEY_TYPE
            && (desc == wfc_pkg::KEY_DESC_RSN || desc == wfc_pkg::KEY_DESC_WPA)
            && ki[wfc_pkg::KI_PAIRWISE])
        begin
            if (ack && !mic && !ins && !sec)
                m = wfc_pkg::MSG_M1;
            else if (!ack && mic && !ins && !sec)
                m = wfc_pkg::MSG_M2;
            else if (ack && mic && ins && sec)
                m = wfc_pkg::MSG_M3;
            else if (!ack && mic && !ins && sec)
                m = wfc_pkg::MSG_M4;
        end
        return m;
    endfunction

    assign take         = octets.valid && octets.ready;
    assign octets.ready = !finish_reg && !q_full;
    assign b            = octets.data_byte;

    assign p17          = {1'b0, pos_reg};
    assign enp17        = {1'b0, enp_reg};
    assign walk_end17   = enp17 + 17'd2 + {9'd0, b};
    assign ssid_first17 = enp17 + 17'd2;
    assign ssid_end17   = ssid_first17 + {9'd0, ilen_reg};
    assign ssid_off17   = p17 - ssid_first17;

    // address 1, 2 or 3 holds the BSSID depending on ToDS/FromDS
    assign bssid_base = (ds_reg == 2'd1) ? 16'd4 : (ds_reg == 2'd2) ? 16'd10 : 16'd16;
    assign in_bssid   = (pos_reg >= bssid_base) && (pos_reg < bssid_base + 16'd6);

    assign tail_full = {tail_reg, b};
    assign snap_hit  = !ef_reg && pos_reg >= wfc_pkg::SNAP_FIRST_END
                       && pos_reg <= wfc_pkg::SNAP_LAST_END
                       && tail_full == wfc_pkg::SNAP_PATTERN;
    assign es16      = 16'(es_reg);

    always_comb
    begin
        pos_next    = pos_reg;
        tail_next   = tail_reg;
        type_next   = type_reg;
        ds_next     = ds_reg;
        bssid_next  = bssid_reg;
        enp_next    = enp_reg;
        eid_next    = eid_reg;
        ilen_next   = ilen_reg;
        walk_next   = walk_reg;
        ef_next     = ef_reg;
        es_next     = es_reg;
        ktype_next  = ktype_reg;
        kdesc_next  = kdesc_reg;
        ki_next     = ki_reg;
        finish_next = finish_reg;
        bank_next   = bank_reg;
        ssid_wr     = '0;

        if (finish_reg)
        begin
            // when the queue has room the summary is pushed this cycle; clear for the next frame
            if (!q_full)
            begin
                pos_next    = '0;
                tail_next   = '0;
                type_next   = '0;
                ds_next     = '0;
                bssid_next  = '0;
                enp_next    = wfc_pkg::IE_WALK_START;
                eid_next    = '0;
                ilen_next   = '0;
                walk_next   = WALK_SEARCH;
                ef_next     = 1'b0;
                es_next     = '0;
                ktype_next  = '0;
                kdesc_next  = '0;
                ki_next     = '0;
                finish_next = 1'b0;
                bank_next   = ~bank_reg;
            end
        end
        else if (take)
        begin
            if (pos_reg != wfc_pkg::POS_SATURATED)
            begin
                pos_next = pos_reg + 16'd1;
                if (pos_reg == 16'd0)
                    type_next = b;
                if (pos_reg == 16'd1)
                    ds_next = b[1:0];
                if (in_bssid)
                    bssid_next = {bssid_reg[39:0], b};

                case (walk_reg)
                    WALK_SEARCH:
                    begin
                        if (pos_reg == enp_reg)
                        begin
                            eid_next = b;
                        end
                        else if (p17 == enp17 + 17'd1)
                        begin
                            ilen_next = b;
                            if (walk_end17[16])
                                walk_next = WALK_FAILED;
                            else if (eid_reg == 8'd0)
                                walk_next = (b > wfc_pkg::SSID_MAX_LEN) ? WALK_FAILED
                                                                        : WALK_CAPTURE;
                            else
                                enp_next = walk_end17[15:0];
                        end
                    end
                    WALK_CAPTURE:
                    begin
                        if (p17 >= ssid_first17 && p17 < ssid_end17)
                        begin
                            ssid_wr.en   = 1'b1;
                            ssid_wr.addr = {bank_reg, ssid_off17[wfc_pkg::SSID_IDX_W-1:0]};
                            ssid_wr.data = b;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                tail_next = tail_full[55:0];
                if (snap_hit)
                begin
                    ef_next = 1'b1;
                    es_next = wfc_pkg::EAPOL_START_W'(pos_reg + 16'd1);
                end
                else if (ef_reg && pos_reg > es16)
                begin
                    if (pos_reg == es16 + 16'd1)
                        ktype_next = b;
                    else if (pos_reg == es16 + 16'd4)
                        kdesc_next = b;
                    else if (pos_reg == es16 + 16'd5)
                        ki_next[15:8] = b;
                    else if (pos_reg == es16 + 16'd6)
                        ki_next[7:0] = b;
                end
            end
            if (octets.last_byte)
                finish_next = 1'b1;
        end
    end

    assign ssid_ok = (walk_reg == WALK_CAPTURE) && (p17 >= ssid_end17);
    assign len_ok  = pos_reg >= wfc_pkg::BSSID_MIN_LEN;
    assign elen    = ef_reg ? (pos_reg - es16) : 16'd0;

    always_comb
    begin
        push_job              = '0;
        push_job.beacon       = (type_reg & wfc_pkg::BEACON_MASK) == wfc_pkg::BEACON_CODE;
        push_job.bssid_valid  = len_ok;
        push_job.bssid        = len_ok ? bssid_reg : 48'd0;
        push_job.ssid_found   = ssid_ok;
        push_job.ssid_len     = ssid_ok ? wfc_pkg::SSID_LEN_W'(ilen_reg) : '0;
        push_job.eapol_found  = ef_reg;
        push_job.eapol_offset = ef_reg ? es_reg : '0;
        push_job.eapol_length = elen;
        push_job.msg          = ef_reg ? classify(elen, ktype_reg, kdesc_reg, ki_reg)
                                       : wfc_pkg::MSG_UNKNOWN;
        push_job.bank         = bank_reg;
    end

    assign push = finish_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            tail_reg   <= '0;
            type_reg   <= '0;
            ds_reg     <= '0;
            bssid_reg  <= '0;
            enp_reg    <= wfc_pkg::IE_WALK_START;
            eid_reg    <= '0;
            ilen_reg   <= '0;
            walk_reg   <= WALK_SEARCH;
            ef_reg     <= 1'b0;
            es_reg     <= '0;
            ktype_reg  <= '0;
            kdesc_reg  <= '0;
            ki_reg     <= '0;
            finish_reg <= 1'b0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            tail_reg   <= tail_next;
            type_reg   <= type_next;
            ds_reg     <= ds_next;
            bssid_reg  <= bssid_next;
            enp_reg    <= enp_next;
            eid_reg    <= eid_next;
            ilen_reg   <= ilen_next;
            walk_reg   <= walk_next;
            ef_reg     <= ef_next;
            es_reg     <= es_next;
            ktype_reg  <= ktype_next;
            kdesc_reg  <= kdesc_next;
            ki_reg     <= ki_next;
            finish_reg <= finish_next;
            bank_reg   <= bank_next;
        end
    end

endmodule

>>> rtl/core/wfc_queue.sv
`timescale 1ns / 1ps

module wfc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wfc_pkg::frame_job_t push_job,
    input  logic                pop,
    output logic                full,
    output logic                nonempty,
    output wfc_pkg::frame_job_t head
);

    wfc_pkg::frame_job_t slot_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;

    assign full     = count_reg == 2'd2;
    assign nonempty = count_reg != 2'd0;
    assign head     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
            count_next  = count_next + 2'd1;
        end
        if (pop && nonempty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
            count_next  = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/wfc_back.sv
`timescale 1ns / 1ps

module wfc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               nonempty,
    input  wfc_pkg::frame_job_t                head,
    output logic                               pop,
    output logic                               rd_en,
    output logic [wfc_pkg::SSID_RAM_AW-1:0]    rd_addr,
    input  logic [7:0]                         rd_data,
    wfc_out_if.source                          results
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_SUMMARY,
        B_LOAD,
        B_OCTET
    } back_state_t;

    typedef struct packed {
        logic        kind;
        logic        beacon;
        logic        bssid_valid;
        logic [47:0] bssid;
        logic        ssid_found;
        logic [5:0]  ssid_len;
        logic        eapol_found;
        logic [5:0]  eapol_offset;
        logic [15:0] eapol_length;
        logic [2:0]  msg;
        logic [7:0]  octet;
        logic        last;
    } result_t;

    back_state_t                     state_reg, state_next;
    result_t                         res_reg, res_next;
    logic                            valid_reg, valid_next;
    logic [wfc_pkg::SSID_LEN_W-1:0]  k_reg, k_next;
    logic                            out_take;

    assign out_take = valid_reg && results.ready;
    assign rd_addr  = {head.bank, k_reg[wfc_pkg::SSID_IDX_W-1:0]};

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        valid_next = valid_reg;
        k_next     = k_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (nonempty)
                begin
                    res_next              = '0;
                    res_next.beacon       = head.beacon;
                    res_next.bssid_valid  = head.bssid_valid;
                    res_next.bssid        = head.bssid;
                    res_next.ssid_found   = head.ssid_found;
                    res_next.ssid_len     = 6'(head.ssid_len);
                    res_next.eapol_found  = head.eapol_found;
                    res_next.eapol_offset = 6'(head.eapol_offset);
                    res_next.eapol_length = head.eapol_length;
                    res_next.msg          = head.msg;
                    res_next.last         = head.ssid_len == '0;
                    valid_next            = 1'b1;
                    k_next                = '0;
                    state_next            = B_SUMMARY;
                end
            end
            B_SUMMARY, B_OCTET:
            begin
                if (out_take)
                begin
                    valid_next = 1'b0;
                    if (res_reg.last)
                    begin
                        pop        = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        // fetch the next SSID octet; the registered read data is captured in B_LOAD
                        rd_en      = 1'b1;
                        k_next     = k_reg + 1'b1;
                        state_next = B_LOAD;
                    end
                end
            end
            B_LOAD:
            begin
                res_next       = '0;
                res_next.kind  = 1'b1;
                res_next.octet = rd_data;
                res_next.last  = k_reg == head.ssid_len;
                valid_next     = 1'b1;
                state_next     = B_OCTET;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
            k_reg     <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            k_reg     <= k_next;
            res_reg   <= res_next;
        end
    end

    assign results.valid             = valid_reg;
    assign results.result_kind       = res_reg.kind;
    assign results.beacon_flag       = res_reg.beacon;
    assign results.bssid_valid       = res_reg.bssid_valid;
    assign results.bssid_value       = res_reg.bssid;
    assign results.ssid_found        = res_reg.ssid_found;
    assign results.ssid_length       = res_reg.ssid_len;
    assign results.eapol_found       = res_reg.eapol_found;
    assign results.eapol_offset      = res_reg.eapol_offset;
    assign results.eapol_length      = res_reg.eapol_length;
    assign results.handshake_message = res_reg.msg;
    assign results.ssid_octet        = res_reg.octet;
    assign results.last_result       = res_reg.last;

endmodule

>>> rtl/core/wlan_frame_classifier.sv
`timescale 1ns / 1ps

// Channel   Modport  Payload                                   Per request
// octets    sink     data_byte, last_byte                      one frame octet
// results   source   kind, flags, BSSID, SSID/EAPOL fields,    frame summary or
//                    handshake message, ssid_octet, last       one SSID octet
//
// Octets are taken one per cycle when not stalled; the cycle after a frame's
// final octet it stalls until the summary is queued and the tracker clears.
// Results: the summary is registered from the queue head before it is shown;
// each SSID octet comes from a registered read of the SSID RAM, captured in
// B_LOAD and shown in B_OCTET.
// Up to two finished frames wait in the job queue; with both held, input stalls.
// rst_n clears all control state asynchronously; the SSID RAM has no reset.

module wlan_frame_classifier (
    input  logic      clk,
    input  logic      rst_n,
    wfc_in_if.sink    octets,
    wfc_out_if.source results
);

    logic                                 push;
    wfc_pkg::frame_job_t                  push_job;
    wfc_pkg::frame_job_t                  head_job;
    wfc_pkg::ssid_wr_t                    ssid_wr;
    logic                                 q_full;
    logic                                 q_nonempty;
    logic                                 pop;
    logic                                 rd_en;
    logic [wfc_pkg::SSID_RAM_AW-1:0]      rd_addr;
    logic [7:0]                           rd_data;

    wfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .octets   (octets),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job),
        .ssid_wr  (ssid_wr)
    );

    wfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (head_job)
    );

    wfc_ram #(
        .WIDTH (8),
        .DEPTH (wfc_pkg::SSID_RAM_DEPTH)
    ) u_ssid_ram (
        .clk   (clk),
        .we    (ssid_wr.en),
        .waddr (ssid_wr.addr),
        .wdata (ssid_wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    wfc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .nonempty (q_nonempty),
        .head     (head_job),
        .pop      (pop),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .results  (results)
    );

    a_summary_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.result_kind |-> q_nonempty)
        else $error("summary shown with no queued frame");

    a_push_bank_alternates: assert property (@(posedge clk) disable iff (!rst_n)
        push && q_nonempty |-> push_job.bank != head_job.bank)
        else $error("new frame uses the bank still being drained");

    a_no_write_to_drain_bank: assert property (@(posedge clk) disable iff (!rst_n)
        ssid_wr.en && q_nonempty |-> ssid_wr.addr[wfc_pkg::SSID_RAM_AW-1] != head_job.bank)
        else $error("SSID write hits the bank being drained");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && results.last_result |=> !results.valid)
        else $error("result shown right after the last of a frame");

endmodule
